// File: rtl/acsc_pkg.sv
// shared types and constants for the argb color space converter
// no dependencies; imported by every module of the block
package acsc_pkg;

	localparam int LUT_INDEX_MAX      = 4080;
	localparam int TBL_LEN            = LUT_INDEX_MAX + 1;
	localparam int LUT_AW             = 12;
	localparam int COEF_FRAC_BITS_DEF = 12;
	localparam int RECIP_SHIFT        = 22;
	localparam logic [15:0] ONE_LIN   = 16'd65280;
	localparam logic [11:0] IDX_MAX   = 12'd4080;

	typedef enum logic [1:0] {
		REQ_PIXEL       = 2'd0,
		REQ_WR_TO_LIN   = 2'd1,
		REQ_WR_FROM_LIN = 2'd2,
		REQ_NONE        = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_IN_PREMUL  = 3'd0,
		CFG_IN_OPAQUE  = 3'd1,
		CFG_OUT_PREMUL = 3'd2,
		CFG_MTX_EN     = 3'd3,
		CFG_COL_RED    = 3'd4,
		CFG_COL_GREEN  = 3'd5,
		CFG_COL_BLUE   = 3'd6
	} cfg_reg_t;

	// sideband that travels with each item through the pipeline
	typedef struct packed {
		logic        valid;
		req_t        req;
		logic [1:0]  ch;
		logic [11:0] idx;
		logic [15:0] val;
		logic [7:0]  alpha;
		logic        last;
		logic        zero_lin;
	} item_ctl_t;

endpackage

// File: rtl/acsc_lut_bank.sv
// one transfer table bank: 16-bit synchronous memory, one read port
// depends on acsc_pkg for the default depth and address width
module acsc_lut_bank
	import acsc_pkg::*;
#(
	parameter int DEPTH = TBL_LEN,
	parameter int AW    = LUT_AW
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/acsc_load_index.sv
// input register and to-linear index computation (three stages)
// depends on acsc_pkg; premultiplied index uses a reciprocal table
module acsc_load_index
	import acsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_prem,
	input  item_ctl_t             ctl_in,
	input  logic [2:0][7:0]       c_in,
	output item_ctl_t             ctl_s3,
	output logic [2:0][LUT_AW-1:0] idx_s3
);

	logic [RECIP_SHIFT-1:0] recip_tbl [256];

	for (genvar i = 0; i < 256; i++) begin : g_recip
		localparam int DIV = (i == 0) ? 1 : 2 * i;
		localparam logic [RECIP_SHIFT-1:0] RV =
			(i == 0) ? '0 : RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / DIV);
		assign recip_tbl[i] = RV;
	end

	item_ctl_t              ctl_s1, ctl_s2;
	logic [2:0][7:0]        c_s1, c_s2, c_s3;
	logic [RECIP_SHIFT-1:0] recip_s1;
	logic [2:0][20:0]       n_s2, n_s3;
	logic [2:0][42:0]       p_s2;
	logic [2:0]             sat_s2, sat_s3;
	logic [2:0][12:0]       q0_s3;
	logic [2:0][21:0]       prod_s3;
	logic [2:0][20:0]       n_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_s1[k] = 21'(c_s1[k]) * 21'd8160 + 21'(ctl_s1.alpha);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1     <= c_in;
			recip_s1 <= recip_tbl[ctl_in.alpha];
			c_s2     <= c_s1;
			c_s3     <= c_s2;
			for (int k = 0; k < 3; k++) begin
				p_s2[k]    <= 43'(n_s1[k]) * 43'(recip_s1);
				n_s2[k]    <= n_s1[k];
				sat_s2[k]  <= c_s1[k] >= ctl_s1.alpha;
				q0_s3[k]   <= p_s2[k][RECIP_SHIFT +: 13];
				prod_s3[k] <= 22'(p_s2[k][RECIP_SHIFT +: 13]) * 22'({ctl_s2.alpha, 1'b0});
				n_s3[k]    <= n_s2[k];
				sat_s3[k]  <= sat_s2[k];
			end
		end
	end

	// one correction step after the reciprocal estimate
	always_comb begin
		logic [20:0] rem;
		logic [12:0] q;
		for (int k = 0; k < 3; k++) begin
			rem = n_s3[k] - prod_s3[k][20:0];
			q   = q0_s3[k] + 13'(rem >= 21'({ctl_s3.alpha, 1'b0}));
			if (!in_prem) begin
				idx_s3[k] = {c_s3[k], 4'b0};
			end else if (sat_s3[k]) begin
				idx_s3[k] = IDX_MAX;
			end else begin
				idx_s3[k] = q[LUT_AW-1:0];
			end
		end
	end

endmodule

// File: rtl/acsc_matrix.sv
// 3x3 signed matrix on linear values: products, then sum, shift and clamp
// depends on acsc_pkg
module acsc_matrix
	import acsc_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             mtx_en,
	input  logic [2:0][47:0] cols,
	input  item_ctl_t        ctl_in,
	input  logic [2:0][15:0] lin_in,
	output item_ctl_t        ctl_s6,
	output logic [2:0][15:0] res_s6
);

	item_ctl_t                      ctl_s5;
	logic signed [2:0][2:0][32:0]   prod_s5;
	logic [2:0][15:0]               lin_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			ctl_s5 <= ctl_in;
			ctl_s6 <= ctl_s5;
		end
	end

	// row k output, column j input
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s5 <= lin_in;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s5[k][j] <= 33'($signed(cols[j][16*k +: 16]))
						* $signed({17'b0, lin_in[j]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [34:0] sum;
		logic signed [34:0] shd;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sum = 35'($signed(prod_s5[k][0])) + 35'($signed(prod_s5[k][1]))
					+ 35'($signed(prod_s5[k][2]));
				shd = sum >>> COEF_FRAC_BITS;
				if (!mtx_en) begin
					res_s6[k] <= lin_s5[k];
				end else if (sum < 0) begin
					res_s6[k] <= '0;
				end else if (shd > 35'(ONE_LIN)) begin
					res_s6[k] <= ONE_LIN;
				end else begin
					res_s6[k] <= shd[15:0];
				end
			end
		end
	end

endmodule

// File: rtl/argb_color_space_converter.sv
// top level of the argb color space converter: config registers, table banks,
// store index and output scaling; depends on acsc_pkg, acsc_lut_bank,
// acsc_load_index and acsc_matrix
//
// One pixel per clock is sustained: every stage advances together whenever the
// output register is empty or its transfer completes, so in_ready only drops
// while a finished result waits for the consumer. A pixel passes the load index,
// table, matrix and scaling stages, then the output register. The six transfer
// tables are separate banks of 4081 x 16 bits with a read and a write port, one
// per channel and direction; a table write request travels down the pipeline and
// is written at the very stage where pixels read that table, so writes and pixel
// lookups take effect in stream order. Table contents are undefined until written
// and need no clearing after reset. Configuration writes are taken at any time
// (cfg_ready is always high) but must only happen while the pipeline is empty.
module argb_color_space_converter
	import acsc_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [1:0]  lut_channel,
	input  logic [11:0] lut_index,
	input  logic [15:0] lut_value,
	input  logic [7:0]  in_alpha,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic        last_pixel,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_alpha,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_out
);

	// configuration registers
	logic             in_prem_q, opaque_q, out_prem_q, mtx_en_q;
	logic [2:0][47:0] cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_prem_q  <= 1'b0;
			opaque_q   <= 1'b0;
			out_prem_q <= 1'b0;
			mtx_en_q   <= 1'b0;
			cols_q[0]  <= 48'd4096;
			cols_q[1]  <= 48'd4096 << 16;
			cols_q[2]  <= 48'd4096 << 32;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IN_PREMUL:  in_prem_q  <= cfg_data[0];
				CFG_IN_OPAQUE:  opaque_q   <= cfg_data[0];
				CFG_OUT_PREMUL: out_prem_q <= cfg_data[0];
				CFG_MTX_EN:     mtx_en_q   <= cfg_data[0];
				CFG_COL_RED:    cols_q[0]  <= cfg_data;
				CFG_COL_GREEN:  cols_q[1]  <= cfg_data;
				CFG_COL_BLUE:   cols_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register can take a result
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	item_ctl_t       ctl_in;
	logic [2:0][7:0] c_in;

	always_comb begin
		ctl_in.valid    = in_valid;
		ctl_in.req      = req_t'(req_type);
		ctl_in.ch       = lut_channel;
		ctl_in.idx      = lut_index;
		ctl_in.val      = lut_value;
		ctl_in.alpha    = in_alpha;
		ctl_in.last     = last_pixel;
		// premultiplied pixel with zero alpha skips the to-linear lookup
		ctl_in.zero_lin = in_prem_q && (in_alpha == 8'd0);
		c_in            = {in_blue, in_green, in_red};
	end

	// stages 1..3: load index
	item_ctl_t              ctl_s3;
	logic [2:0][LUT_AW-1:0] ld_idx_s3;

	acsc_load_index u_load (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_prem (in_prem_q),
		.ctl_in  (ctl_in),
		.c_in    (c_in),
		.ctl_s3  (ctl_s3),
		.idx_s3  (ld_idx_s3)
	);

	// to-linear banks: read or write at stage 3, data at stage 4
	item_ctl_t        ctl_s4;
	logic [2:0][15:0] tl_data;
	logic [2:0][15:0] lin_s4;
	logic             wr_ok_s3;

	assign wr_ok_s3 = ctl_s3.valid && (ctl_s3.idx <= IDX_MAX);

	for (genvar k = 0; k < 3; k++) begin : g_tl
		acsc_lut_bank u_bank (
			.clk     (clk),
			.rd_en   (adv && ctl_s3.valid && ctl_s3.req == REQ_PIXEL),
			.rd_addr (ld_idx_s3[k]),
			.rd_data (tl_data[k]),
			.wr_en   (adv && wr_ok_s3 && ctl_s3.req == REQ_WR_TO_LIN
				&& ctl_s3.ch == 2'(k)),
			.wr_addr (ctl_s3.idx),
			.wr_data (ctl_s3.val)
		);
		assign lin_s4[k] = ctl_s4.zero_lin ? 16'd0 : tl_data[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl_s3;
		end
	end

	// stages 5..6: matrix
	item_ctl_t        ctl_s6;
	logic [2:0][15:0] res_s6;

	acsc_matrix #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mtx (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.mtx_en (mtx_en_q),
		.cols   (cols_q),
		.ctl_in (ctl_s4),
		.lin_in (lin_s4),
		.ctl_s6 (ctl_s6),
		.res_s6 (res_s6)
	);

	// store index (L+8)>>4 saturated, from-linear lookup at stage 6
	logic [2:0][LUT_AW-1:0] st_idx_s6;
	logic                   wr_ok_s6;

	always_comb begin
		logic [16:0] rnd;
		for (int k = 0; k < 3; k++) begin
			rnd = 17'(res_s6[k]) + 17'd8;
			st_idx_s6[k] = (rnd[16:4] > 13'(IDX_MAX)) ? IDX_MAX : rnd[15:4];
		end
	end

	assign wr_ok_s6 = ctl_s6.valid && (ctl_s6.idx <= IDX_MAX);

	item_ctl_t        ctl_s7, ctl_s8;
	logic [2:0][15:0] v_s7;

	for (genvar k = 0; k < 3; k++) begin : g_fl
		acsc_lut_bank u_bank (
			.clk     (clk),
			.rd_en   (adv && ctl_s6.valid && ctl_s6.req == REQ_PIXEL),
			.rd_addr (st_idx_s6[k]),
			.rd_data (v_s7[k]),
			.wr_en   (adv && wr_ok_s6 && ctl_s6.req == REQ_WR_FROM_LIN
				&& ctl_s6.ch == 2'(k)),
			.wr_addr (ctl_s6.idx),
			.wr_data (ctl_s6.val)
		);
	end

	// stage 8: value times alpha for premultiplied output
	logic [2:0][15:0] v_s8;
	logic [2:0][23:0] va_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (adv) begin
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				v_s8[k]  <= v_s7[k];
				va_s8[k] <= 24'(v_s7[k]) * 24'(ctl_s7.alpha);
			end
		end
	end

	// final scaling: round(va/65280) as floor(floor(y/256)/255), or (v+128)>>8
	logic [2:0][7:0] o_s8;

	always_comb begin
		logic [24:0] y;
		logic [16:0] z;
		logic [16:0] r;
		logic [9:0]  q;
		logic [16:0] w;
		for (int k = 0; k < 3; k++) begin
			y = 25'(va_s8[k]) + 25'd32640;
			z = y[24:8];
			q = 10'(z[16:8]);
			r = z - (({8'b0, z[16:8]} << 8) - 17'(z[16:8]));
			if (r >= 17'd255) begin
				r = r - 17'd255;
				q = q + 10'd1;
			end
			if (r >= 17'd255) begin
				q = q + 10'd1;
			end
			w = 17'(v_s8[k]) + 17'd128;
			if (!opaque_q && out_prem_q) begin
				o_s8[k] = (q > 10'd255) ? 8'hFF : q[7:0];
			end else begin
				o_s8[k] = w[16] ? 8'hFF : w[15:8];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_s8.valid && ctl_s8.req == REQ_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_alpha <= opaque_q ? 8'hFF : ctl_s8.alpha;
			out_red   <= o_s8[0];
			out_green <= o_s8[1];
			out_blue  <= o_s8[2];
			last_out  <= ctl_s8.last;
		end
	end

	// every pixel leaving stage 8 becomes a result
	a_pixel_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s8.valid && ctl_s8.req == REQ_PIXEL |=> out_valid)
		else $error("pixel lost at output register");

	// table writes and unknown requests never make a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !(ctl_s8.valid && ctl_s8.req == REQ_PIXEL) |=> !out_valid)
		else $error("result from a non-pixel request");

	// a stalled pipeline keeps its middle stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_s6))
		else $error("stage 6 moved during stall");

	// opaque mode forces full alpha
	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && opaque_q |-> out_alpha == 8'hFF)
		else $error("opaque output alpha not full");

endmodule

// File: tb/argb_color_space_converter_checker.sv
// checker for the argb color space converter: mirrors config and tables,
// predicts each pixel result and compares it with the output channel
// depends on acsc_pkg
`timescale 1ns / 1ps
module argb_color_space_converter_checker
	import acsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [1:0]  lut_channel,
	input  logic [11:0] lut_index,
	input  logic [15:0] lut_value,
	input  logic [7:0]  in_alpha,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic        last_pixel,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_alpha,
	input  logic [7:0]  out_red,
	input  logic [7:0]  out_green,
	input  logic [7:0]  out_blue,
	input  logic        last_out,
	output int          errors,
	output int          pending,
	output int          pixels_seen
);

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} argb_t;

	argb_t       expected_pixels[$];
	logic [15:0] to_lin[3][TBL_LEN];
	logic [15:0] from_lin[3][TBL_LEN];
	logic        prem_in, opaque, prem_out, mtx_on;
	logic [47:0] col[3];

	assign pending = expected_pixels.size();

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint load_idx(longint c, longint a);
		longint i;
		i = (2 * c * LUT_INDEX_MAX + a) / (2 * a);
		return i > LUT_INDEX_MAX ? LUT_INDEX_MAX : i;
	endfunction

	function automatic argb_t convert(logic [7:0] a, logic [7:0] c[3], logic last);
		longint lin[3], res[3], s, v, o, si;
		argb_t  p;
		for (int k = 0; k < 3; k++) begin
			if (prem_in && a == 0) lin[k] = 0;
			else lin[k] = to_lin[k][load_idx(c[k], prem_in ? a : 255)];
		end
		if (mtx_on) begin
			for (int k = 0; k < 3; k++) begin
				s = 0;
				for (int j = 0; j < 3; j++)
					s += longint'($signed(col[j][16*k +: 16])) * lin[j];
				s = s < 0 ? 0 : (s >>> 12);
				res[k] = s > ONE_LIN ? ONE_LIN : s;
			end
			lin = res;
		end
		for (int k = 0; k < 3; k++) begin
			si = (2 * lin[k] * LUT_INDEX_MAX + ONE_LIN) / (2 * longint'(ONE_LIN));
			if (si > LUT_INDEX_MAX) si = LUT_INDEX_MAX;
			v = from_lin[k][si];
			if (!opaque && prem_out) o = (2 * v * a + ONE_LIN) / (2 * longint'(ONE_LIN));
			else o = (v + 128) >> 8;
			if (o > 255) o = 255;
			if (k == 0) p.r = o[7:0];
			else if (k == 1) p.g = o[7:0];
			else p.b = o[7:0];
		end
		p.a = opaque ? 8'd255 : a;
		p.last = last;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] c[3];
		argb_t      want;
		if (!arst_n) begin
			errors <= 0;
			pixels_seen <= 0;
			prem_in = 0; opaque = 0; prem_out = 0; mtx_on = 0;
			col[0] = 48'd4096; col[1] = 48'd4096 << 16; col[2] = 48'd4096 << 32;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_IN_PREMUL:  prem_in = cfg_data[0];
					CFG_IN_OPAQUE:  opaque = cfg_data[0];
					CFG_OUT_PREMUL: prem_out = cfg_data[0];
					CFG_MTX_EN:     mtx_on = cfg_data[0];
					CFG_COL_RED:    col[0] = cfg_data;
					CFG_COL_GREEN:  col[1] = cfg_data;
					CFG_COL_BLUE:   col[2] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_WR_TO_LIN || req_type == REQ_WR_FROM_LIN) begin
					if (lut_channel < 3 && lut_index <= IDX_MAX) begin
						if (req_type == REQ_WR_TO_LIN) to_lin[lut_channel][lut_index] = lut_value;
						else from_lin[lut_channel][lut_index] = lut_value;
					end
				end else if (req_type == REQ_PIXEL) begin
					c[0] = in_red; c[1] = in_green; c[2] = in_blue;
					expected_pixels.push_back(convert(in_alpha, c, last_pixel));
				end
			end
			if (out_valid && out_ready) begin
				pixels_seen <= pixels_seen + 1;
				if (expected_pixels.size() == 0) begin
					report("unexpected transfer", 1, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (out_alpha !== want.a) report("alpha", out_alpha, want.a);
					if (out_red !== want.r) report("red", out_red, want.r);
					if (out_green !== want.g) report("green", out_green, want.g);
					if (out_blue !== want.b) report("blue", out_blue, want.b);
					if (last_out !== want.last) report("last", last_out, want.last);
				end
			end
		end
	end

endmodule

// File: tb/argb_color_space_converter_test.sv
// testbench top for the argb color space converter: fills the table entries
// that pixels reach, then streams pixels under several configurations;
// depends on acsc_pkg, the converter rtl and argb_color_space_converter_checker
`timescale 1ns / 1ps
module argb_color_space_converter_test;
	import acsc_pkg::*;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid, in_ready;
	logic [1:0]  req_type, lut_channel;
	logic [11:0] lut_index;
	logic [15:0] lut_value;
	logic [7:0]  in_alpha, in_red, in_green, in_blue;
	logic        last_pixel;
	logic        out_valid, out_ready;
	logic [7:0]  out_alpha, out_red, out_green, out_blue;
	logic        last_out;
	int          errors, pending, pixels_seen;
	int          cycles;
	bit          hold_off;   // long receiver stall requested by stimulus
	bit          stim_done;
	bit          cur_prem;   // premultiplied input mode currently set

	localparam int CYCLE_LIMIT = 400000;

	argb_color_space_converter DUT (.*);
	argb_color_space_converter_checker chk (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random ready, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ready <= 1'b0;
		else if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one transfer on the item channel, valid held until accepted;
	// valid drops only in a gap or when the stream goes idle
	task automatic send(input req_t rq, input logic [1:0] ch, input logic [11:0] ix,
			input logic [15:0] v, input logic [7:0] a, r, g, b, input logic lst);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq; lut_channel <= ch; lut_index <= ix; lut_value <= v;
		in_alpha <= a; in_red <= r; in_green <= g; in_blue <= b; last_pixel <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic pixel(input logic [7:0] a, r, g, b);
		send(REQ_PIXEL, 2'($urandom), 12'($urandom), 16'($urandom), a, r, g, b,
			1'($urandom));
	endtask

	// colors are even or full scale, so load indices are multiples of 32 or the top
	function automatic logic [7:0] rand_chan();
		if ($urandom_range(0, 15) == 0) return 8'd255;
		return {7'($urandom), 1'b0};
	endfunction

	// premultiplied alpha is zero or divides 255, keeping load indices on the same grid
	function automatic logic [7:0] prem_alpha();
		case ($urandom_range(0, 8))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd3;
			3: return 8'd5;
			4: return 8'd15;
			5: return 8'd17;
			6: return 8'd51;
			7: return 8'd85;
			default: return 8'd255;
		endcase
	endfunction

	task automatic random_pixel();
		logic [7:0] a;
		if (cur_prem) a = prem_alpha();
		else a = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
		pixel(a, rand_chan(), rand_chan(), rand_chan());
	endtask

	// to-linear values stay multiples of 512 so store indices stay on the grid
	task automatic random_write();
		req_t        rq;
		logic [15:0] v;
		rq = req_t'($urandom_range(1, 3));
		v  = (rq == REQ_WR_TO_LIN) ? {7'($urandom), 9'h0} : 16'($urandom);
		send(rq, 2'($urandom), 12'($urandom), v, 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic write_cfg(input cfg_reg_t ix, input logic [47:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= ix; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain: every expected pixel out, then the pipeline latency
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_mode(input bit pi, op, po, me);
		drain();
		cur_prem = pi;
		write_cfg(CFG_IN_PREMUL, 48'(pi));
		write_cfg(CFG_IN_OPAQUE, 48'(op));
		write_cfg(CFG_OUT_PREMUL, 48'(po));
		write_cfg(CFG_MTX_EN, 48'(me));
	endtask

	task automatic set_matrix(input logic [47:0] r, g, b);
		drain();
		write_cfg(CFG_COL_RED, r);
		write_cfg(CFG_COL_GREEN, g);
		write_cfg(CFG_COL_BLUE, b);
	endtask

	// whole-number coefficients keep matrix sums multiples of 512
	function automatic logic [47:0] rand_col();
		return {4'($urandom), 12'h0, 4'($urandom), 12'h0, 4'($urandom), 12'h0};
	endfunction

	initial begin
		int          ix;
		logic [15:0] v;
		arst_n = 1'b0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; req_type = 0; lut_channel = 0; lut_index = 0; lut_value = 0;
		in_alpha = 0; in_red = 0; in_green = 0; in_blue = 0; last_pixel = 0;
		hold_off = 0; stim_done = 0; cycles = 0; cur_prem = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// fill every entry that a pixel can reach (multiples of 32 and the top);
		// the extreme values sit at the ends of each table
		for (int t = 0; t < 2; t++)
			for (int ch = 0; ch < 3; ch++)
				for (int m = 0; m <= 128; m++) begin
					ix = (m == 128) ? LUT_INDEX_MAX : 32 * m;
					if (m == 0) v = 16'h0;
					else if (t == 0) v = (m == 128) ? 16'hfe00 : {7'($urandom), 9'h0};
					else v = (m == 128) ? 16'hffff : 16'($urandom);
					send(req_t'(t ? REQ_WR_FROM_LIN : REQ_WR_TO_LIN), 2'(ch), 12'(ix), v,
						8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
				end

		// directed: ignored writes, unknown request, field extremes
		send(REQ_WR_TO_LIN, 2'd3, 12'd5, 16'hffff, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send(REQ_WR_FROM_LIN, 2'd1, 12'd4095, 16'h1234, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
		send(REQ_NONE, 2'd2, 12'hfff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
		pixel(8'd0, 8'd0, 8'd0, 8'd0);
		pixel(8'd255, 8'd255, 8'd255, 8'd255);
		pixel(8'd128, 8'd2, 8'd126, 8'd200);
		set_mode(1'b1, 1'b0, 1'b1, 1'b0);
		pixel(8'd0, 8'd255, 8'd10, 8'd0);      // zero alpha, premultiplied
		pixel(8'd1, 8'd255, 8'd1, 8'd0);       // index saturates
		pixel(8'd255, 8'd255, 8'd0, 8'd128);
		set_mode(1'b0, 1'b1, 1'b1, 1'b1);
		pixel(8'd77, 8'd255, 8'd0, 8'd32);
		set_matrix(48'hf000_8000_7000, 48'h8000_7000_f000, 48'h0000_f000_8000);
		pixel(8'd255, 8'd255, 8'd255, 8'd255);
		pixel(8'd9, 8'd0, 8'd128, 8'd255);

		// random phases, each with its own setting
		for (int ph = 0; ph < 8; ph++) begin
			set_mode(1'($urandom), 1'($urandom), 1'($urandom), ph % 4 != 0);
			if (ph == 7) set_matrix(48'd4096, 48'd4096 << 16, 48'd4096 << 32);
			else set_matrix(rand_col(), rand_col(), rand_col());
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 19) == 0) random_write();
				else random_pixel();
			end
		end
		// long receiver stall while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int n = 0; n < 40; n++) random_pixel();
		join

		drain();
		$display("covered table fills, bad and unknown requests, several mode settings");
		$display("and %0d pixel results across directed and random phases", pixels_seen);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: argb_color_space_converter.f
rtl/acsc_pkg.sv
rtl/acsc_lut_bank.sv
rtl/acsc_load_index.sv
rtl/acsc_matrix.sv
rtl/argb_color_space_converter.sv
tb/argb_color_space_converter_checker.sv
tb/argb_color_space_converter_test.sv
